// ===== sv/pvic_pkg.sv =====
// Shared types and constants for the pump and valve irrigation controller.
package pvic_pkg;

  // Fixed field widths
  localparam int unsigned MoistW  = 7;
  localparam int unsigned HourW   = 5;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    ReqSample = 2'd0,
    ReqPump   = 2'd1,
    ReqValve  = 2'd2
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMoistureThreshold = 3'd0,
    CfgStartHour         = 3'd1,
    CfgEndHour           = 3'd2,
    CfgDryStopTicks      = 3'd3,
    CfgMaxRunTicks       = 3'd4,
    CfgValveDelayTicks   = 3'd5,
    CfgDebounceTicks     = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [MoistW-1:0] MoistThreshRst = 7'd30;
  localparam logic [HourW-1:0]  StartHourRst   = 5'd6;
  localparam logic [HourW-1:0]  EndHourRst     = 5'd20;
  localparam logic [TickW-1:0]  DryStopRst     = 32'd10000;
  localparam logic [TickW-1:0]  MaxRunRst      = 32'd600000;
  localparam logic [TickW-1:0]  ValveDelayRst  = 32'd30000;
  localparam logic [TickW-1:0]  DebounceRst    = 32'd2000;

  typedef struct packed {
    logic [MoistW-1:0] moisture_threshold;
    logic [HourW-1:0]  hour_first;
    logic [HourW-1:0]  hour_stop;
    logic [TickW-1:0]  dry_stop_ticks;
    logic [TickW-1:0]  max_run_ticks;
    logic [TickW-1:0]  valve_delay_ticks;
    logic [TickW-1:0]  debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic              manual_on;
    logic [TickW-1:0]  stamp_tick;
    logic [HourW-1:0]  hour;
    logic              level_upper;
    logic              level_supply;
    logic [MoistW-1:0] moisture;
  } item_t;

  typedef struct packed {
    logic pump_on;
    logic valve_on;
    logic pump_started;
    logic stop_dry;
    logic stop_timeout;
    logic valve_opened;
    logic valve_closed;
    logic level_changed;
    logic stable_upper;
    logic stable_supply;
  } result_t;

endpackage

// ===== sv/pvic_cfg_regs.sv =====
// Configuration register file of the irrigation controller.
module pvic_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pvic_pkg::CfgIdxW-1:0]         cfg_addr_i,
  input  logic [pvic_pkg::CfgDataW-1:0]        cfg_data_i,
  output pvic_pkg::cfg_t                       cfg_o
);

  pvic_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write beat; unknown indexes drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (pvic_pkg::cfg_idx_e'(cfg_addr_i))
        pvic_pkg::CfgMoistureThreshold:
          cfg_d.moisture_threshold = cfg_data_i[pvic_pkg::MoistW-1:0];
        pvic_pkg::CfgStartHour:       cfg_d.hour_first = cfg_data_i[pvic_pkg::HourW-1:0];
        pvic_pkg::CfgEndHour:         cfg_d.hour_stop = cfg_data_i[pvic_pkg::HourW-1:0];
        pvic_pkg::CfgDryStopTicks:    cfg_d.dry_stop_ticks = cfg_data_i;
        pvic_pkg::CfgMaxRunTicks:     cfg_d.max_run_ticks = cfg_data_i;
        pvic_pkg::CfgValveDelayTicks: cfg_d.valve_delay_ticks = cfg_data_i;
        pvic_pkg::CfgDebounceTicks:   cfg_d.debounce_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.moisture_threshold <= pvic_pkg::MoistThreshRst;
      cfg_q.hour_first         <= pvic_pkg::StartHourRst;
      cfg_q.hour_stop          <= pvic_pkg::EndHourRst;
      cfg_q.dry_stop_ticks     <= pvic_pkg::DryStopRst;
      cfg_q.max_run_ticks      <= pvic_pkg::MaxRunRst;
      cfg_q.valve_delay_ticks  <= pvic_pkg::ValveDelayRst;
      cfg_q.debounce_ticks     <= pvic_pkg::DebounceRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/pvic_core.sv =====
// Controller state and the combinational update for one sample or command.
module pvic_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  pvic_pkg::item_t   item_i,
  input  pvic_pkg::cfg_t    cfg_i,
  output pvic_pkg::result_t result_o
);

  localparam int unsigned CmpW = (TIME_WIDTH > pvic_pkg::TickW) ? TIME_WIDTH : pvic_pkg::TickW;

  logic pump_q, pump_d, valve_q, valve_d, armed_q, armed_d;
  logic dry_pend_q, dry_pend_d, lvl_pend_q, lvl_pend_d;
  logic held_up_q, held_up_d, held_sup_q, held_sup_d, loaded_q, loaded_d;
  logic [TIME_WIDTH-1:0] start_q, start_d, stop_q, stop_d;
  logic [TIME_WIDTH-1:0] dry_since_q, dry_since_d, lvl_since_q, lvl_since_d;
  logic [TIME_WIDTH-1:0] now;
  logic started, sdry, stout, vopen, vclose, lchg;

  // Wrapped elapsed time reached a 32-bit threshold
  function automatic logic elapsed_ge(input logic [TIME_WIDTH-1:0] a,
                                      input logic [TIME_WIDTH-1:0] b,
                                      input logic [pvic_pkg::TickW-1:0] thr);
    logic [TIME_WIDTH-1:0] diff;
    logic [CmpW-1:0]       lhs;
    logic [CmpW-1:0]       rhs;
    diff = TIME_WIDTH'(a - b);
    lhs  = CmpW'(diff);
    rhs  = CmpW'(thr);
    return lhs >= rhs;
  endfunction

  assign now = TIME_WIDTH'(item_i.stamp_tick);

  // Next state for the item in the input register
  always_comb begin
    pump_d      = pump_q;
    valve_d     = valve_q;
    armed_d     = armed_q;
    dry_pend_d  = dry_pend_q;
    lvl_pend_d  = lvl_pend_q;
    held_up_d   = held_up_q;
    held_sup_d  = held_sup_q;
    loaded_d    = loaded_q;
    start_d     = start_q;
    stop_d      = stop_q;
    dry_since_d = dry_since_q;
    lvl_since_d = lvl_since_q;
    started = 1'b0;
    sdry    = 1'b0;
    stout   = 1'b0;
    vopen   = 1'b0;
    vclose  = 1'b0;
    lchg    = 1'b0;
    unique case (pvic_pkg::req_type_e'(item_i.req_type))
      pvic_pkg::ReqPump: begin
        pump_d = item_i.manual_on;
        if (item_i.manual_on) begin
          start_d = now;
        end else begin
          stop_d  = now;
          armed_d = 1'b1;
        end
      end
      pvic_pkg::ReqValve: begin
        valve_d = item_i.manual_on;
      end
      pvic_pkg::ReqSample: begin
        // Load levels on the first sample, then debounce
        if (!loaded_q) begin
          held_up_d  = item_i.level_upper;
          held_sup_d = item_i.level_supply;
          loaded_d   = 1'b1;
        end
        if (item_i.level_upper != held_up_d || item_i.level_supply != held_sup_d) begin
          if (!lvl_pend_q) begin
            lvl_pend_d  = 1'b1;
            lvl_since_d = now;
          end
          if (elapsed_ge(now, lvl_since_d, cfg_i.debounce_ticks)) begin
            held_up_d  = item_i.level_upper;
            held_sup_d = item_i.level_supply;
            lvl_pend_d = 1'b0;
            lchg       = 1'b1;
          end
        end else begin
          lvl_pend_d = 1'b0;
        end

        // Pump start inside the window, or dry and timeout stops
        if (!pump_q) begin
          if (item_i.hour >= cfg_i.hour_first && item_i.hour < cfg_i.hour_stop &&
              item_i.level_supply && item_i.moisture < cfg_i.moisture_threshold) begin
            pump_d  = 1'b1;
            start_d = now;
            started = 1'b1;
          end
        end else begin
          if (!item_i.level_supply) begin
            if (!dry_pend_q) begin
              dry_pend_d  = 1'b1;
              dry_since_d = now;
            end
            if (elapsed_ge(now, dry_since_d, cfg_i.dry_stop_ticks)) begin
              pump_d     = 1'b0;
              stop_d     = now;
              armed_d    = 1'b1;
              dry_pend_d = 1'b0;
              sdry       = 1'b1;
            end
          end else begin
            dry_pend_d = 1'b0;
          end
          if (elapsed_ge(now, start_q, cfg_i.max_run_ticks)) begin
            pump_d  = 1'b0;
            stop_d  = now;
            armed_d = 1'b1;
            stout   = 1'b1;
          end
        end

        // Valve open after the stop delay, close at upper level
        if (!pump_d && armed_d && !valve_q && !item_i.level_upper &&
            elapsed_ge(now, stop_d, cfg_i.valve_delay_ticks)) begin
          valve_d = 1'b1;
          vopen   = 1'b1;
        end
        if (valve_d && item_i.level_upper) begin
          valve_d = 1'b0;
          armed_d = 1'b0;
          vclose  = 1'b1;
        end
        if (armed_d && valve_d) begin
          armed_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_o.pump_on       = pump_d;
    result_o.valve_on      = valve_d;
    result_o.pump_started  = started;
    result_o.stop_dry      = sdry;
    result_o.stop_timeout  = stout;
    result_o.valve_opened  = vopen;
    result_o.valve_closed  = vclose;
    result_o.level_changed = lchg;
    result_o.stable_upper  = held_up_d;
    result_o.stable_supply = held_sup_d;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q      <= 1'b0;
      valve_q     <= 1'b0;
      armed_q     <= 1'b0;
      dry_pend_q  <= 1'b0;
      lvl_pend_q  <= 1'b0;
      held_up_q   <= 1'b0;
      held_sup_q  <= 1'b0;
      loaded_q    <= 1'b0;
      start_q     <= '0;
      stop_q      <= '0;
      dry_since_q <= '0;
      lvl_since_q <= '0;
    end else if (fire_i) begin
      pump_q      <= pump_d;
      valve_q     <= valve_d;
      armed_q     <= armed_d;
      dry_pend_q  <= dry_pend_d;
      lvl_pend_q  <= lvl_pend_d;
      held_up_q   <= held_up_d;
      held_sup_q  <= held_sup_d;
      loaded_q    <= loaded_d;
      start_q     <= start_d;
      stop_q      <= stop_d;
      dry_since_q <= dry_since_d;
      lvl_since_q <= lvl_since_d;
    end
  end

endmodule

// ===== sv/pump_valve_irrigation_controller_top.sv =====
// Top level of the pump and valve irrigation controller with stream ports.
// The block takes one sensor sample or manual command per clock cycle while
// the output side keeps up, and returns one result beat for each after it
// has passed through the input register and then the result register.
// The controller state (pump, valve, debounce and delay marks) is read and
// rewritten as an item moves from the input register to the result
// register, and that update sets the rate of one item per cycle. Time
// stamps wrap modulo 2^TIME_WIDTH.
// Configuration writes always complete in the cycle they are offered and are
// meant to happen only while no item is in flight.
module pump_valve_irrigation_controller_top #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input beat
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [0] manual_on, [32:1] time stamp, [37:33] hour, [38] level_upper,
  // [39] level_supply, [46:40] moisture, [47] zero
  input  logic [pvic_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]                     s_axis_tuser_i,
  // Result beat
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] pump_on, [1] valve_on, [2] pump_started, [3] stop_dry,
  // [4] stop_timeout, [5] valve_opened, [6] valve_closed, [7] level_changed,
  // [8] stable_upper, [9] stable_supply, [15:10] zero
  output logic [pvic_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pvic_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [pvic_pkg::CfgDataW-1:0]  cfg_data_i
);

  pvic_pkg::cfg_t    cfg;
  pvic_pkg::item_t   in_item_q, in_item_d;
  pvic_pkg::result_t result;
  logic              in_valid_q, out_valid_q;
  logic              fire, out_free;
  logic [pvic_pkg::OutDataW-1:0] out_data_q, out_data_d;

  pvic_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance when the result register is empty or being drained
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || fire;

  // Unpack the input beat
  always_comb begin
    in_item_d.req_type     = s_axis_tuser_i;
    in_item_d.manual_on    = s_axis_tdata_i[0];
    in_item_d.stamp_tick   = s_axis_tdata_i[32:1];
    in_item_d.hour         = s_axis_tdata_i[37:33];
    in_item_d.level_upper  = s_axis_tdata_i[38];
    in_item_d.level_supply = s_axis_tdata_i[39];
    in_item_d.moisture     = s_axis_tdata_i[46:40];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q <= in_item_d;
    end
  end

  pvic_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Pack the result beat
  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = result.pump_on;
    out_data_d[1]     = result.valve_on;
    out_data_d[2]     = result.pump_started;
    out_data_d[3]     = result.stop_dry;
    out_data_d[4]     = result.stop_timeout;
    out_data_d[5]     = result.valve_opened;
    out_data_d[6]     = result.valve_closed;
    out_data_d[7]     = result.level_changed;
    out_data_d[8]     = result.stable_upper;
    out_data_d[9]     = result.stable_supply;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking stream testbench for the pump and valve irrigation controller.
module tb;
  import pvic_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0] ReqSpare = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd7;
  localparam logic [TickW-1:0] TickMax = 32'hFFFF_FFFF;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pump_valve_irrigation_controller_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Result field names in tdata bit order
  string result_field [10] = '{"pump_on", "valve_on", "pump_started", "stop_dry",
                               "stop_timeout", "valve_opened", "valve_closed",
                               "level_changed", "stable_upper", "stable_supply"};

  item_t   request_q [$];
  result_t status_q [$];
  item_t   cur_item;
  int      errors = 0;
  int      cycles = 0;
  logic [TickW-1:0] field_tick;

  // Controller shadow: configuration and state
  cfg_t             cfg_m = '{MoistThreshRst, StartHourRst, EndHourRst, DryStopRst,
                              MaxRunRst, ValveDelayRst, DebounceRst};
  logic             pump_run = 1'b0;
  logic             valve_open = 1'b0;
  logic             valve_due = 1'b0;
  logic             dry_mark = 1'b0;
  logic             lvl_mark = 1'b0;
  logic             st_upper = 1'b0;
  logic             st_supply = 1'b0;
  logic             lvl_loaded = 1'b0;
  logic [TickW-1:0] run_since = '0;
  logic [TickW-1:0] stop_at = '0;
  logic [TickW-1:0] dry_at = '0;
  logic [TickW-1:0] lvl_at = '0;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    if (errors < 100) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Advance the controller by one request and return its drive report
  function automatic result_t irrigation_step(item_t it);
    result_t          r;
    logic             upper;
    logic             supply;
    logic [TickW-1:0] now;
    logic [TickW-1:0] span;
    r = '0;
    upper = it.level_upper;
    supply = it.level_supply;
    now = it.stamp_tick;
    case (it.req_type)
      ReqPump: begin
        pump_run = it.manual_on;
        if (it.manual_on) begin
          run_since = now;
        end else begin
          stop_at = now;
          valve_due = 1'b1;
        end
      end
      ReqValve: valve_open = it.manual_on;
      ReqSample: begin
        // Debounce the level switches; the first sample just loads them
        if (!lvl_loaded) begin
          st_upper = upper;
          st_supply = supply;
          lvl_loaded = 1'b1;
        end
        if (upper != st_upper || supply != st_supply) begin
          if (!lvl_mark) begin
            lvl_mark = 1'b1;
            lvl_at = now;
          end
          span = now - lvl_at;
          if (span >= cfg_m.debounce_ticks) begin
            st_upper = upper;
            st_supply = supply;
            lvl_mark = 1'b0;
            r.level_changed = 1'b1;
          end
        end else begin
          lvl_mark = 1'b0;
        end
        // Pump start inside the window, or dry and run-time stops
        if (!pump_run) begin
          if (it.hour >= cfg_m.hour_first && it.hour < cfg_m.hour_stop && supply &&
              it.moisture < cfg_m.moisture_threshold) begin
            pump_run = 1'b1;
            run_since = now;
            r.pump_started = 1'b1;
          end
        end else begin
          if (!supply) begin
            if (!dry_mark) begin
              dry_mark = 1'b1;
              dry_at = now;
            end
            span = now - dry_at;
            if (span >= cfg_m.dry_stop_ticks) begin
              pump_run = 1'b0;
              stop_at = now;
              valve_due = 1'b1;
              dry_mark = 1'b0;
              r.stop_dry = 1'b1;
            end
          end else begin
            dry_mark = 1'b0;
          end
          span = now - run_since;
          if (span >= cfg_m.max_run_ticks) begin
            pump_run = 1'b0;
            stop_at = now;
            valve_due = 1'b1;
            r.stop_timeout = 1'b1;
          end
        end
        // Valve opens after the stop delay, closes at the upper level
        span = now - stop_at;
        if (!pump_run && valve_due && !valve_open && span >= cfg_m.valve_delay_ticks &&
            !upper) begin
          valve_open = 1'b1;
          r.valve_opened = 1'b1;
        end
        if (valve_open && upper) begin
          valve_open = 1'b0;
          valve_due = 1'b0;
          r.valve_closed = 1'b1;
        end
        if (valve_due && valve_open) valve_due = 1'b0;
      end
      default: ;
    endcase
    r.pump_on = pump_run;
    r.valve_on = valve_open;
    r.stable_upper = st_upper;
    r.stable_supply = st_supply;
    return r;
  endfunction

  // Input driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) status_q.push_back(irrigation_step(cur_item));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_item = request_q.pop_front();
          s_axis_tdata_i <= {1'b0, cur_item.moisture, cur_item.level_supply,
                             cur_item.level_upper, cur_item.hour, cur_item.stamp_tick,
                             cur_item.manual_on};
          s_axis_tuser_i <= cur_item.req_type;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: rotating stall pattern plus long hold-offs
  int ready_phase = 0;
  int hold_left = 0;
  int next_hold = 600;
  int rx_beats = 0;

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) rx_beats++;
    ready_phase++;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_beats >= next_hold) begin
      hold_left = 200;
      next_hold += 800;
      m_axis_tready_i <= 1'b0;
    end else begin
      case ((ready_phase >> 6) & 3)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= 1'($urandom_range(0, 1));
        2: m_axis_tready_i <= ((ready_phase & 3) == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  // Result checker
  int result_seq = 0;

  always @(posedge clk_i) begin
    result_t    want;
    logic [9:0] want_bits;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (status_q.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d (%h) with no request outstanding",
                                result_seq, m_axis_tdata_o));
      end else begin
        want = status_q.pop_front();
        want_bits = {want.stable_supply, want.stable_upper, want.level_changed,
                     want.valve_closed, want.valve_opened, want.stop_timeout,
                     want.stop_dry, want.pump_started, want.valve_on, want.pump_on};
        for (int b = 0; b < 10; b++) begin
          if (m_axis_tdata_o[b] !== want_bits[b])
            flag_mismatch($sformatf("result beat %0d %s: got %b, want %b", result_seq,
                                    result_field[b], m_axis_tdata_o[b], want_bits[b]));
        end
      end
      result_seq++;
    end
  end

  // Hold until every request is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid_i || status_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgMoistureThreshold: cfg_m.moisture_threshold = data[MoistW-1:0];
      CfgStartHour:         cfg_m.hour_first = data[HourW-1:0];
      CfgEndHour:           cfg_m.hour_stop = data[HourW-1:0];
      CfgDryStopTicks:      cfg_m.dry_stop_ticks = data;
      CfgMaxRunTicks:       cfg_m.max_run_ticks = data;
      CfgValveDelayTicks:   cfg_m.valve_delay_ticks = data;
      CfgDebounceTicks:     cfg_m.debounce_ticks = data;
      default: ;
    endcase
  endtask

  task automatic queue_request(logic [1:0] req, logic on, logic [TickW-1:0] t,
                               logic [HourW-1:0] h, logic up, logic sup,
                               logic [MoistW-1:0] m);
    item_t it;
    it.req_type = req;
    it.manual_on = on;
    it.stamp_tick = t;
    it.hour = h;
    it.level_upper = up;
    it.level_supply = sup;
    it.moisture = m;
    request_q.push_back(it);
  endtask

  // Program one full register set: minimum, maximum, inverted window or random
  task automatic program_phase(int ph);
    logic [CfgDataW-1:0] thr, hr_lo, hr_hi, dry, run, vdl, deb;
    case (ph)
      1: begin
        {thr, hr_lo, hr_hi, dry, run, vdl, deb} = '0;
      end
      2: begin
        thr = 100;
        hr_lo = 23;
        hr_hi = 24;
        {dry, run, vdl, deb} = {4{TickMax}};
      end
      default: begin
        thr = $urandom_range(20, 100);
        hr_lo = $urandom_range(0, 10);
        hr_hi = $urandom_range(12, 24);
        dry = $urandom_range(0, 200);
        run = $urandom_range(0, 1500);
        vdl = $urandom_range(0, 300);
        deb = $urandom_range(0, 60);
        if (ph == 3) begin
          hr_lo = $urandom_range(12, 23);
          hr_hi = $urandom_range(0, hr_lo);
        end
        // Fill the unused upper bits of the narrow registers
        thr |= $urandom << MoistW;
        hr_lo |= $urandom << HourW;
        hr_hi |= $urandom << HourW;
      end
    endcase
    write_reg(CfgMoistureThreshold, thr);
    write_reg(CfgStartHour, hr_lo);
    write_reg(CfgEndHour, hr_hi);
    write_reg(CfgDryStopTicks, dry);
    write_reg(CfgMaxRunTicks, run);
    write_reg(CfgValveDelayTicks, vdl);
    write_reg(CfgDebounceTicks, deb);
    write_reg(CfgSpareIdx, $urandom);
  endtask

  // Field run: mostly samples with advancing time and slowly moving levels
  task automatic queue_field_run(int count, logic [TickW-1:0] step_max);
    item_t it;
    int    roll;
    logic  upper_raw;
    logic  supply_raw;
    upper_raw = 1'($urandom_range(0, 1));
    supply_raw = 1'b1;
    field_tick = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFF_FC00;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) field_tick = $urandom;
      else if (step_max == TickMax) field_tick += $urandom;
      else field_tick += $urandom_range(0, step_max);
      if ($urandom_range(0, supply_raw ? 11 : 4) == 0) supply_raw = ~supply_raw;
      if ($urandom_range(0, 9) == 0) upper_raw = ~upper_raw;
      it.req_type = (roll < 6) ? ReqPump : (roll < 10) ? ReqValve :
                    (roll < 12) ? ReqSpare : ReqSample;
      it.manual_on = 1'($urandom_range(0, 1));
      it.stamp_tick = field_tick;
      it.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) :
                                             5'($urandom_range(0, 23));
      // Occasional single-sample glitch on either switch
      it.level_upper = upper_raw ^ ($urandom_range(0, 19) == 0);
      it.level_supply = supply_raw ^ ($urandom_range(0, 19) == 0);
      it.moisture = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 100)) :
                                                 7'($urandom_range(0, 35));
      if (it.req_type == ReqSpare) it.stamp_tick = $urandom;
      request_q.push_back(it);
    end
  endtask

  // Stimulus sequence
  initial begin
    @(posedge rst_ni);
    // Directed walk under the reset settings
    queue_request(ReqSample, 1'b0, 32'd0, 5'd0, 1'b1, 1'b1, 7'd100);
    queue_request(ReqSample, 1'b0, 32'd100, 5'd31, 1'b0, 1'b1, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd2100, 5'd12, 1'b0, 1'b1, 7'd0);
    queue_request(ReqSample, 1'b1, 32'd3000, 5'd12, 1'b0, 1'b0, 7'd50);
    queue_request(ReqSample, 1'b0, 32'd13000, 5'd12, 1'b0, 1'b0, 7'd50);
    queue_request(ReqSample, 1'b0, 32'd43000, 5'd12, 1'b0, 1'b0, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd44000, 5'd12, 1'b1, 1'b0, 7'd0);
    queue_request(ReqPump, 1'b1, 32'd50000, 5'd12, 1'b1, 1'b0, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd50100, 5'd12, 1'b1, 1'b0, 7'd0);
    // Dry and run-time stop on the same sample
    queue_request(ReqSample, 1'b0, 32'd650100, 5'd12, 1'b1, 1'b0, 7'd0);
    queue_request(ReqPump, 1'b0, 32'd650200, 5'd12, 1'b1, 1'b0, 7'd0);
    queue_request(ReqValve, 1'b1, 32'd650300, 5'd12, 1'b1, 1'b0, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd650400, 5'd12, 1'b1, 1'b1, 7'd0);
    // A manually opened valve clears the armed delay
    queue_request(ReqPump, 1'b0, 32'd650500, 5'd12, 1'b0, 1'b1, 7'd0);
    queue_request(ReqValve, 1'b1, 32'd650600, 5'd12, 1'b0, 1'b1, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd650700, 5'd3, 1'b0, 1'b1, 7'd99);
    queue_request(ReqValve, 1'b0, 32'd650800, 5'd3, 1'b0, 1'b1, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd700000, 5'd5, 1'b0, 1'b1, 7'd0);
    // Start just below the wrap, then a run-time stop that leaves a dry mark
    queue_request(ReqSample, 1'b0, 32'hFFFF_FFF0, 5'd19, 1'b0, 1'b1, 7'd29);
    queue_request(ReqSample, 1'b0, 32'd599974, 5'd19, 1'b0, 1'b0, 7'd29);
    queue_request(ReqSample, 1'b0, 32'd599984, 5'd19, 1'b0, 1'b0, 7'd29);
    // The stale dry mark stops the next run at once
    queue_request(ReqPump, 1'b1, 32'd620000, 5'd12, 1'b0, 1'b0, 7'd0);
    queue_request(ReqSample, 1'b0, 32'd620010, 5'd12, 1'b0, 1'b0, 7'd0);
    queue_request(ReqSpare, 1'b1, TickMax, 5'd31, 1'b1, 1'b1, 7'd100);
    queue_request(ReqSample, 1'b1, TickMax, 5'd23, 1'b1, 1'b1, 7'd100);
    wait_drained();

    for (int ph = 1; ph <= 7; ph++) begin
      program_phase(ph);
      queue_field_run((ph <= 2) ? 150 : 300, (ph == 1) ? 32'd20 : (ph == 2) ? TickMax : 32'd60);
      wait_drained();
    end

    // Let any stray result beat show up
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pvic_pkg.sv
sv/pvic_cfg_regs.sv
sv/pvic_core.sv
sv/pump_valve_irrigation_controller_top.sv
dv/tb.sv
